// ===== rtl/hashed_value_noise_2d_macros.svh =====
// Assertion macros for the value noise RTL.
`ifndef HASHED_VALUE_NOISE_2D_MACROS_SVH
`define HASHED_VALUE_NOISE_2D_MACROS_SVH
`ifndef NO_ASSERTIONS
`define HVN_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("value noise assertion failed");
`define HVN_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("value noise assertion failed");
`else
`define HVN_ASSERT_NOW(label, ante, cons)
`define HVN_ASSERT_NEXT(label, ante, cons)
`endif
`endif

// ===== rtl/hvn_pkg.sv =====
// Constants for the hashed value noise pipeline.
package hvn_pkg;
	localparam int unsigned Q_BITS = 16;
	localparam logic [31:0] HASH_MUL_X   = 32'd374761393;
	localparam logic [31:0] HASH_MUL_Y   = 32'd668265263;
	localparam logic [31:0] HASH_MUL_MIX = 32'd1274126177;
	localparam logic [13:0] HASH_MOD     = 14'd10000;
	// floor(n / 10000) == (n * DIV_MAGIC) >> DIV_SHIFT for any 32-bit n
	localparam logic [31:0] DIV_MAGIC    = 32'hD1B71759;
	localparam int unsigned DIV_SHIFT    = 45;
	// 3.0 in Q16
	localparam logic [17:0] SMOOTH_THREE = 18'd196608;
	typedef logic [Q_BITS-1:0] q16_t;
endpackage

// ===== rtl/hashed_value_noise_2d.sv =====
// Top level: pipelined 2D hashed value noise with smoothstep bilinear blend.
// Use: push one point per request on the s_axis channel; tdata carries coord_x
// in bits [31:0] and coord_y in bits [63:32], both signed with FRAC_BITS
// fractional bits. Each point returns one noise sample on the m_axis channel,
// unsigned Q0.16 in tdata[15:0], in request order.
// Throughput is one point per cycle while m_axis_tready stays high; the eight
// register stages are set by the 32x32 hash multiplies, the reciprocal
// multiplies of the mod-10000 reduction and of the Q0.16 scaling, and the two
// blend multiplies, each with a register behind it.
// Reset clears every stage valid bit; the pipeline then accepts at once.
// When the receiver holds m_axis_tready low, the output stage holds its
// sample and upstream stages keep filling bubbles; s_axis_tready drops only
// once every stage holds a sample.
`include "hashed_value_noise_2d_macros.svh"
module hashed_value_noise_2d #(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,   // [31:0] coord_x, [63:32] coord_y
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata    // [15:0] noise_value
);
	localparam int STAGES = 8;

	logic [STAGES:1]   vld_q;
	logic [STAGES+1:1] rdy;

	logic [31:0] coord_x, coord_y, cell_x, cell_y;
	hvn_pkg::q16_t fx_d, fy_d;

	assign coord_x = s_axis_tdata[31:0];
	assign coord_y = s_axis_tdata[63:32];
	assign cell_x  = 32'($signed(coord_x) >>> FRAC_BITS);
	assign cell_y  = 32'($signed(coord_y) >>> FRAC_BITS);

	if (FRAC_BITS >= 16) begin : g_frac_trunc
		assign fx_d = coord_x[FRAC_BITS-1 -: 16];
		assign fy_d = coord_y[FRAC_BITS-1 -: 16];
	end else begin : g_frac_widen
		assign fx_d = {coord_x[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
		assign fy_d = {coord_y[FRAC_BITS-1:0], {(16-FRAC_BITS){1'b0}}};
	end

	// Handshake: a stage loads when it is empty or the next one moves
	always_comb begin
		rdy[STAGES+1] = m_axis_tready;
		for (int k = STAGES; k >= 1; k--) begin
			rdy[k] = !vld_q[k] || rdy[k+1];
		end
	end

	assign s_axis_tready = rdy[1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			if (rdy[1]) begin
				vld_q[1] <= s_axis_tvalid;
			end
			for (int k = 2; k <= STAGES; k++) begin
				if (rdy[k]) begin
					vld_q[k] <= vld_q[k-1];
				end
			end
		end
	end

	// Stage 1: lattice products and fraction squares
	logic [31:0]   hx_s1, hy_s1;
	hvn_pkg::q16_t fx_s1, fy_s1, fxx_s1, fyy_s1;
	logic [31:0]   fxx_d, fyy_d;

	assign fxx_d = 32'(fx_d) * 32'(fx_d);
	assign fyy_d = 32'(fy_d) * 32'(fy_d);

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			hx_s1  <= cell_x * hvn_pkg::HASH_MUL_X;
			hy_s1  <= cell_y * hvn_pkg::HASH_MUL_Y;
			fx_s1  <= fx_d;
			fy_s1  <= fy_d;
			fxx_s1 <= fxx_d[31:16];
			fyy_s1 <= fyy_d[31:16];
		end
	end

	// Stage 2: corner sums, first mix, smoothstep
	logic [3:0][31:0] n_d, m_d, m_s2;
	logic [33:0]      sxp_d, syp_d;
	logic [16:0]      sx_s2, sy_s2;

	always_comb begin
		n_d[0] = hx_s1 + hy_s1;
		n_d[1] = hx_s1 + hvn_pkg::HASH_MUL_X + hy_s1;
		n_d[2] = hx_s1 + hy_s1 + hvn_pkg::HASH_MUL_Y;
		n_d[3] = hx_s1 + hvn_pkg::HASH_MUL_X + hy_s1 + hvn_pkg::HASH_MUL_Y;
		for (int c = 0; c < 4; c++) begin
			m_d[c] = n_d[c] ^ (n_d[c] >> 13);
		end
	end

	assign sxp_d = 34'(fxx_s1) * 34'(hvn_pkg::SMOOTH_THREE - {1'b0, fx_s1, 1'b0});
	assign syp_d = 34'(fyy_s1) * 34'(hvn_pkg::SMOOTH_THREE - {1'b0, fy_s1, 1'b0});

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			m_s2  <= m_d;
			sx_s2 <= sxp_d[32:16];
			sy_s2 <= syp_d[32:16];
		end
	end

	// Stage 3: mix multiply
	logic [3:0][31:0] h_s3;
	logic [16:0]      sx_s3, sy_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int c = 0; c < 4; c++) begin
				h_s3[c] <= m_s2[c] * hvn_pkg::HASH_MUL_MIX;
			end
			sx_s3 <= sx_s2;
			sy_s3 <= sy_s2;
		end
	end

	// Stage 4: final mix, quotient by 10000 through the reciprocal
	logic [3:0][31:0] f_d, f_s4;
	logic [3:0][63:0] qp_d;
	logic [3:0][18:0] q_s4;
	logic [16:0]      sx_s4, sy_s4;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			f_d[c]  = h_s3[c] ^ (h_s3[c] >> 16);
			qp_d[c] = 64'(f_d[c]) * 64'(hvn_pkg::DIV_MAGIC);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int c = 0; c < 4; c++) begin
				q_s4[c] <= qp_d[c][hvn_pkg::DIV_SHIFT +: 19];
			end
			f_s4  <= f_d;
			sx_s4 <= sx_s3;
			sy_s4 <= sy_s3;
		end
	end

	// Stage 5: remainder
	logic [3:0][13:0] r_s5;
	logic [16:0]      sx_s5, sy_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			for (int c = 0; c < 4; c++) begin
				r_s5[c] <= 14'(f_s4[c] - 32'(q_s4[c]) * 32'(hvn_pkg::HASH_MOD));
			end
			sx_s5 <= sx_s4;
			sy_s5 <= sy_s4;
		end
	end

	// Stage 6: scale remainder to Q0.16, r * 65536 / 10000
	logic [3:0][63:0]      vp_d;
	hvn_pkg::q16_t [3:0]   val_s6;
	logic [16:0]           sx_s6, sy_s6;

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			vp_d[c] = 64'({r_s5[c], 16'd0}) * 64'(hvn_pkg::DIV_MAGIC);
		end
	end

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int c = 0; c < 4; c++) begin
				val_s6[c] <= vp_d[c][hvn_pkg::DIV_SHIFT +: 16];
			end
			sx_s6 <= sx_s5;
			sy_s6 <= sy_s5;
		end
	end

	// Stage 7: blend along x
	logic signed [16:0] dx0_d, dx1_d;
	logic signed [34:0] px0_d, px1_d, sh0_d, sh1_d;
	logic [16:0]        bx0_d, bx1_d;
	hvn_pkg::q16_t      nx0_s7, nx1_s7;
	logic [16:0]        sy_s7;

	assign dx0_d = $signed({1'b0, val_s6[1]}) - $signed({1'b0, val_s6[0]});
	assign dx1_d = $signed({1'b0, val_s6[3]}) - $signed({1'b0, val_s6[2]});
	assign px0_d = dx0_d * $signed({1'b0, sx_s6});
	assign px1_d = dx1_d * $signed({1'b0, sx_s6});
	assign sh0_d = px0_d >>> 16;
	assign sh1_d = px1_d >>> 16;
	assign bx0_d = {1'b0, val_s6[0]} + sh0_d[16:0];
	assign bx1_d = {1'b0, val_s6[2]} + sh1_d[16:0];

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			nx0_s7 <= bx0_d[15:0];
			nx1_s7 <= bx1_d[15:0];
			sy_s7  <= sy_s6;
		end
	end

	// Stage 8: blend along y, output register
	logic signed [16:0] dy_d;
	logic signed [34:0] py_d, shy_d;
	logic [16:0]        by_d;
	hvn_pkg::q16_t      noise_s8;

	assign dy_d  = $signed({1'b0, nx1_s7}) - $signed({1'b0, nx0_s7});
	assign py_d  = dy_d * $signed({1'b0, sy_s7});
	assign shy_d = py_d >>> 16;
	assign by_d  = {1'b0, nx0_s7} + shy_d[16:0];

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			noise_s8 <= by_d[15:0];
		end
	end

	assign m_axis_tvalid = vld_q[STAGES];
	assign m_axis_tdata  = noise_s8;

	`HVN_ASSERT_NEXT(a_accept_fills_s1, s_axis_tvalid && s_axis_tready, vld_q[1])
	`HVN_ASSERT_NOW(a_noise_range, m_axis_tvalid, m_axis_tdata <= 16'd65529)
	`HVN_ASSERT_NOW(a_rem_range, vld_q[5], r_s5[0] < hvn_pkg::HASH_MOD && r_s5[3] < hvn_pkg::HASH_MOD)
	`HVN_ASSERT_NOW(a_smooth_range, vld_q[3], sx_s3 <= 17'd65536 && sy_s3 <= 17'd65536)
endmodule

// ===== sim/tb_hashed_value_noise_2d.sv =====
// Self-checking testbench for the 2D hashed value noise pipeline.
`timescale 1ns / 1ps

module tb_hashed_value_noise_2d;

	localparam int FRAC_BITS = 16;
	localparam int RANDOM_PER_PHASE = 133;
	localparam int NUM_PHASES = 4;
	localparam int STALL_LIMIT = 2000;
	localparam int DRAIN_CYCLES = 16;

	// Packs exactly as s_axis_tdata: coord_x in the low word.
	typedef struct packed {
		logic signed [31:0] coord_y;
		logic signed [31:0] coord_x;
	} point_t;

	typedef struct {
		point_t        pt;
		hvn_pkg::q16_t noise;
	} noise_check_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [63:0] s_axis_tdata = '0;  // [31:0] coord_x, [63:32] coord_y
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;       // [15:0] noise_value

	point_t       pending_points[$];
	noise_check_t pending_noise[$];
	noise_check_t head;

	int  idle_pct = 0;
	int  stall_pct = 0;
	logic point_taken = 1'b0;
	int  fail_count = 0;
	int  points_sent = 0;
	int  samples_seen = 0;
	int  idle_cycles = 0;

	hashed_value_noise_2d #(
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Hash one lattice corner to a Q0.16 value.
	function automatic longint corner_noise(logic [31:0] ix, logic [31:0] iy);
		logic [31:0] n;
		n = ix * hvn_pkg::HASH_MUL_X + iy * hvn_pkg::HASH_MUL_Y;
		n = (n ^ (n >> 13)) * hvn_pkg::HASH_MUL_MIX;
		n = n ^ (n >> 16);
		return (longint'(n % 32'd10000) * 65536) / longint'(hvn_pkg::HASH_MOD);
	endfunction

	function automatic longint ease_q16(longint f);
		longint f2;
		f2 = (f * f) >>> 16;
		return (f2 * (3 * 65536 - 2 * f)) >>> 16;
	endfunction

	// Arithmetic shift of a signed difference rounds toward minus infinity.
	function automatic longint lerp_q16(longint a, longint b, longint s);
		return a + (((b - a) * s) >>> 16);
	endfunction

	function automatic hvn_pkg::q16_t noise_at(point_t pt);
		logic [31:0] cx0, cy0;
		longint fx, fy, sx, sy, top, bottom, r;
		cx0 = pt.coord_x >>> FRAC_BITS;
		cy0 = pt.coord_y >>> FRAC_BITS;
		fx = longint'(pt.coord_x & ((32'sd1 <<< FRAC_BITS) - 1));
		fy = longint'(pt.coord_y & ((32'sd1 <<< FRAC_BITS) - 1));
		if (FRAC_BITS >= 16) begin
			fx = fx >> (FRAC_BITS - 16);
			fy = fy >> (FRAC_BITS - 16);
		end else begin
			fx = fx << (16 - FRAC_BITS);
			fy = fy << (16 - FRAC_BITS);
		end
		sx = ease_q16(fx);
		sy = ease_q16(fy);
		top = lerp_q16(corner_noise(cx0, cy0), corner_noise(cx0 + 1, cy0), sx);
		bottom = lerp_q16(corner_noise(cx0, cy0 + 1), corner_noise(cx0 + 1, cy0 + 1), sx);
		r = lerp_q16(top, bottom, sy);
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return hvn_pkg::q16_t'(r);
	endfunction

	// Mix of wide random, small lattice range, fraction edges and range wrap.
	function automatic logic [31:0] rand_coord();
		logic [31:0] c;
		logic [15:0] frac_edge[6] = '{16'h0000, 16'h0001, 16'h7FFF, 16'h8000, 16'hFFFE,
			16'hFFFF};
		c = $urandom;
		case ($urandom_range(3))
			0: ;
			1: c[31:16] = {{12{c[19]}}, c[19:16]};
			2: c[15:0] = frac_edge[$urandom_range(5)];
			default: c[31:16] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
		endcase
		return c;
	endfunction

	task automatic note_failure(string msg);
		fail_count++;
		if (fail_count <= 10)
			$display("%s", msg);
	endtask

	// Append a point to the tail of the send queue.
	task automatic queue_point(point_t pt);
		pending_points.insert(pending_points.size(), pt);
	endtask

	// Drive requests and the receiver's ready between rising edges.
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata <= '0;
			m_axis_tready <= 1'b0;
		end else begin
			m_axis_tready <= ($urandom_range(99) >= stall_pct);
			if (!s_axis_tvalid || point_taken) begin
				if (pending_points.size() != 0 && $urandom_range(99) >= idle_pct) begin
					s_axis_tdata <= pending_points.pop_front();
					s_axis_tvalid <= 1'b1;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	// Check results first, then log the new request, so one edge stays ordered.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			point_taken <= 1'b0;
		end else begin
			point_taken <= s_axis_tvalid && s_axis_tready;
			if (m_axis_tvalid && m_axis_tready) begin
				samples_seen++;
				if (pending_noise.size() == 0) begin
					note_failure($sformatf("unexpected sample %0d", m_axis_tdata));
				end else begin
					head = pending_noise.pop_front();
					if (m_axis_tdata !== head.noise)
						note_failure($sformatf(
							"noise mismatch at x=%h y=%h: expected %0d, got %0d",
							head.pt.coord_x, head.pt.coord_y, head.noise, m_axis_tdata));
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				points_sent++;
				pending_noise.insert(pending_noise.size(), '{pt: point_t'(s_axis_tdata),
					noise: noise_at(point_t'(s_axis_tdata))});
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("timeout: no transfer for %0d cycles", STALL_LIMIT);
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		point_t directed[$];
		int idle_plan[NUM_PHASES];
		int stall_plan[NUM_PHASES];

		idle_plan = '{0, 51, 0, 22};
		stall_plan = '{0, 0, 51, 22};

		// Zero, fraction edges, lattice steps, sign flips and wrap of the range.
		directed = '{
			'{32'h0000_0000, 32'h0000_0000}, '{32'h0000_FFFF, 32'h0000_FFFF},
			'{32'h0000_8000, 32'h0000_8000}, '{32'h0000_0000, 32'h0000_0001},
			'{32'h0000_FFFF, 32'h0000_0000}, '{32'h7FFF_FFFF, 32'h7FFF_FFFF},
			'{32'h8000_0000, 32'h8000_0000}, '{32'h8000_0000, 32'h7FFF_FFFF},
			'{32'h7FFF_FFFF, 32'h8000_0000}, '{32'hFFFF_FFFF, 32'hFFFF_FFFF},
			'{32'h0001_0000, 32'hFFFF_0000}, '{32'h7FFF_8000, 32'h7FFF_0000},
			'{32'h7FFF_FFFE, 32'h8000_0001}, '{32'hFFFF_0001, 32'h0001_0001},
			'{32'h9ABC_DEF0, 32'h1234_5678}, '{32'h5555_5555, 32'hAAAA_AAAA},
			'{32'hAAAA_AAAA, 32'h5555_5555}, '{32'h0000_0001, 32'hFFFF_FFFF}
		};

		repeat (4) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			idle_pct = idle_plan[ph];
			stall_pct = stall_plan[ph];
			if (ph == 0)
				foreach (directed[k])
					queue_point(directed[k]);
			for (int k = 0; k < RANDOM_PER_PHASE; k++)
				queue_point('{coord_y: rand_coord(), coord_x: rand_coord()});
			while (pending_points.size() != 0 || s_axis_tvalid || pending_noise.size() != 0)
				@(posedge clk);
		end

		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_noise.size() != 0)
			note_failure($sformatf("%0d samples never arrived", pending_noise.size()));

		$display("covered %0d points (directed edges plus random) under %0d handshake profiles",
			points_sent, NUM_PHASES);
		$display("checked %0d noise samples, %0d failures", samples_seen, fail_count);
		if (fail_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/hvn_pkg.sv
rtl/hashed_value_noise_2d.sv
sim/tb_hashed_value_noise_2d.sv
